>>> rtl/core/tbtu_pkg.sv
// shared constants, codes and types of the terrain brush texel update block
package tbtu_pkg;

    localparam int GRID_SIZE_DEF = 4096;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // brush modes
    localparam logic [2:0] MODE_RAISE   = 3'd0;
    localparam logic [2:0] MODE_LOWER   = 3'd1;
    localparam logic [2:0] MODE_SMOOTH  = 3'd2;
    localparam logic [2:0] MODE_FLATTEN = 3'd3;
    localparam logic [2:0] MODE_PAINT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_CENTER_X = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS   = 3'd3;
    localparam logic [2:0] CFG_FALLOFF  = 3'd4;
    localparam logic [2:0] CFG_RATE     = 3'd5;
    localparam logic [2:0] CFG_FLATTEN  = 3'd6;
    localparam logic [2:0] CFG_CHANNEL  = 3'd7;

    // divide / square root unit
    localparam int DU_OPND_W = 48;
    localparam int DU_DVSR_W = 27;
    localparam int DU_RES_W  = 24;
    localparam int DU_REM_W  = 28;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_du_ctl;

endpackage

>>> rtl/core/terrain_brush_texel_update.sv
// terrain sculpt brush: one texel word in, one updated texel word out
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  texel in | i_in_valid / o_in_ready   | stroke start, x, z, five heights, four splats
//  texel out| o_out_valid / i_out_ready | touched, height, four splats, dirty box
//  config   | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// a word outside the brush never uses the shared unit, nor does a zero-radius hit; otherwise the
// square root (24 steps) and one or two divides (17 steps each) of the shared unit
// dominate, and paint adds four divides unless the splat total is zero.
// o_in_ready is high only while the sequencer is idle; a finished word waits in the
// output register and a new one is finished only after it is taken.
// synchronous active-low reset clears control state and dirty box and loads config defaults; no init pass.
module terrain_brush_texel_update
    import tbtu_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_stroke_start,
    input  logic [11:0] i_texel_x,
    input  logic [11:0] i_texel_z,
    input  logic [16:0] i_height,
    input  logic [16:0] i_left_height,
    input  logic [16:0] i_right_height,
    input  logic [16:0] i_down_height,
    input  logic [16:0] i_up_height,
    input  logic [16:0] i_splat_in_0,
    input  logic [16:0] i_splat_in_1,
    input  logic [16:0] i_splat_in_2,
    input  logic [16:0] i_splat_in_3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_touched,
    output logic [16:0] o_new_height,
    output logic [16:0] o_splat_out_0,
    output logic [16:0] o_splat_out_1,
    output logic [16:0] o_splat_out_2,
    output logic [16:0] o_splat_out_3,
    output logic        o_region_valid,
    output logic [11:0] o_region_min_x,
    output logic [11:0] o_region_max_x,
    output logic [11:0] o_region_min_z,
    output logic [11:0] o_region_max_z
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DX   = 5'd1;
    localparam logic [4:0] S_DZ   = 5'd2;
    localparam logic [4:0] S_RR   = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] S_SQRT = 5'd5;
    localparam logic [4:0] S_DIVT = 5'd6;
    localparam logic [4:0] S_DIVF = 5'd7;
    localparam logic [4:0] S_F2   = 5'd8;
    localparam logic [4:0] S_F3   = 5'd9;
    localparam logic [4:0] S_W    = 5'd10;
    localparam logic [4:0] S_AMT  = 5'd11;
    localparam logic [4:0] S_MODE = 5'd12;
    localparam logic [4:0] S_AVG  = 5'd13;
    localparam logic [4:0] S_MV   = 5'd14;
    localparam logic [4:0] S_MV2  = 5'd15;
    localparam logic [4:0] S_PDIV = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    // ceil(2^21 / 5): exact divide by five for sums below 5 * 2^17
    localparam logic [23:0] DIV5_RECIP = 24'd419431;

    // configuration
    logic [2:0]  r_brush_mode;
    logic [19:0] r_center_x;
    logic [19:0] r_center_z;
    logic [15:0] r_radius;
    logic [16:0] r_falloff;
    logic [23:0] r_rate;
    logic [16:0] r_flatten;
    logic [1:0]  r_channel;

    // item state
    logic [4:0]  r_state;
    logic [11:0] r_x;
    logic [11:0] r_z;
    logic [16:0] r_h;
    logic [19:0] r_sum5;
    logic [25:0] r_sp [4];
    logic [16:0] r_spo [4];
    logic [40:0] r_d2;
    logic [57:0] r_prod;
    logic [16:0] r_f;
    logic [16:0] r_w;
    logic [23:0] r_amt;
    logic [16:0] r_tgt;
    logic        r_up;
    logic [16:0] r_newh;
    logic        r_touched;
    logic [1:0]  r_pi;
    logic        r_pgo;

    // dirty box
    logic        r_dflag;
    logic [11:0] r_dlx, r_dhx, r_dlz, r_dhz;
    logic        n_dflag;
    logic [11:0] n_dlx, n_dhx, n_dlz, n_dhz;

    // output register
    logic        r_out_valid;
    logic        r_o_touched;
    logic [16:0] r_o_height;
    logic [16:0] r_o_sp [4];
    logic        r_o_rvalid;
    logic [11:0] r_o_lx, r_o_hx, r_o_lz, r_o_hz;

    // shared multiplier
    logic [33:0] mul_a;
    logic [23:0] mul_b;
    logic [57:0] mul_p;

    // shared divide / sqrt unit
    t_du_ctl                du_ctl;
    logic [DU_OPND_W-1:0]   du_opnd;
    logic [DU_DVSR_W-1:0]   du_dvsr;
    logic                   du_busy;
    logic                   du_done;
    logic [DU_RES_W-1:0]    du_res;

    logic        accept;
    logic [20:0] dx_s, dz_s;
    logic [19:0] adx, adz;
    logic        grid_ok;
    logic        in_brush;
    logic [16:0] fo;
    logic [16:0] edge_v;
    logic [16:0] t_v;
    logic [23:0] amt_v;
    logic [16:0] tdiff;
    logic [26:0] mag;
    logic [27:0] hsum;
    logic [24:0] rsum;
    logic [25:0] total;
    logic        out_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        dx_s     = {1'b0, r_x, 8'd0} - {1'b0, r_center_x};
        dz_s     = {1'b0, r_z, 8'd0} - {1'b0, r_center_z};
        adx      = dx_s[20] ? 20'(-dx_s) : dx_s[19:0];
        adz      = dz_s[20] ? 20'(-dz_s) : dz_s[19:0];
        grid_ok  = (32'(r_x) < GRID_SIZE) && (32'(r_z) < GRID_SIZE);
        in_brush = grid_ok && (r_brush_mode <= MODE_PAINT) && (r_d2 <= {9'd0, r_prod[31:0]});
        fo       = (r_falloff > ONE_Q16) ? ONE_Q16 : r_falloff;
        edge_v   = ONE_Q16 - fo;
        t_v      = (du_res > 24'(ONE_Q16)) ? ONE_Q16 : du_res[16:0];
        amt_v    = r_prod[39:16];
        tdiff    = (r_tgt >= r_h) ? (r_tgt - r_h) : (r_h - r_tgt);
        mag      = r_prod[40:14];
        hsum     = {11'd0, r_h} + {1'b0, mag};
        rsum     = {8'd0, r_h} + {1'b0, amt_v};
        total    = r_sp[0] + r_sp[1] + r_sp[2] + r_sp[3];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DX: begin
                mul_a = 34'(adx);
                mul_b = 24'(adx);
            end
            S_DZ: begin
                mul_a = 34'(adz);
                mul_b = 24'(adz);
            end
            S_RR: begin
                mul_a = 34'(r_radius);
                mul_b = 24'(r_radius);
            end
            S_F2: begin
                mul_a = 34'(r_f);
                mul_b = 24'(r_f);
            end
            S_F3: begin
                mul_a = r_prod[33:0];
                mul_b = 24'(18'd196608 - {r_f, 1'b0});
            end
            S_AMT: begin
                mul_a = 34'(r_w);
                mul_b = r_rate;
            end
            S_AVG: begin
                mul_a = 34'(r_sum5);
                mul_b = DIV5_RECIP;
            end
            S_MV: begin
                mul_a = 34'(tdiff);
                mul_b = r_amt;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 58'(mul_a) * 58'(mul_b);
    end

    // operand selection for the shared unit
    always_comb begin
        du_ctl  = '0;
        du_opnd = '0;
        du_dvsr = '0;
        case (r_state)
            S_CHK: begin
                du_ctl.start = in_brush && (r_radius != 16'd0);
                du_ctl.sqrt  = 1'b1;
                du_opnd      = {r_d2[31:0], 16'd0};
            end
            S_SQRT: begin
                du_ctl.start = du_done;
                du_opnd      = {16'd0, du_res, 8'd0};
                du_dvsr      = 27'(r_radius);
            end
            S_DIVT: begin
                du_ctl.start = du_done && (t_v < ONE_Q16) && (t_v > edge_v);
                du_opnd      = {15'd0, 17'(t_v - edge_v), 16'd0};
                du_dvsr      = 27'(fo);
            end
            S_PDIV: begin
                du_ctl.start = (total != 26'd0) && !r_pgo;
                du_opnd      = {6'd0, r_sp[r_pi], 16'd0};
                du_dvsr      = 27'(total);
            end
            default: begin
                du_ctl  = '0;
            end
        endcase
    end

    tbtu_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (du_ctl),
        .i_opnd   (du_opnd),
        .i_dvsr   (du_dvsr),
        .o_busy   (du_busy),
        .o_done   (du_done),
        .o_result (du_res)
    );

    // dirty box grows over touched texels
    always_comb begin
        n_dflag = r_dflag;
        n_dlx   = r_dlx;
        n_dhx   = r_dhx;
        n_dlz   = r_dlz;
        n_dhz   = r_dhz;
        if (r_touched) begin
            n_dflag = 1'b1;
            if (!r_dflag) begin
                n_dlx = r_x;
                n_dhx = r_x;
                n_dlz = r_z;
                n_dhz = r_z;
            end else begin
                if (r_x < r_dlx) n_dlx = r_x;
                if (r_x > r_dhx) n_dhx = r_x;
                if (r_z < r_dlz) n_dlz = r_z;
                if (r_z > r_dhz) n_dhz = r_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush_mode <= MODE_RAISE;
            r_center_x   <= '0;
            r_center_z   <= '0;
            r_radius     <= 16'd256;
            r_falloff    <= 17'd32768;
            r_rate       <= 24'd65536;
            r_flatten    <= '0;
            r_channel    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:     r_brush_mode <= i_cfg_data[2:0];
                CFG_CENTER_X: r_center_x   <= i_cfg_data[19:0];
                CFG_CENTER_Z: r_center_z   <= i_cfg_data[19:0];
                CFG_RADIUS:   r_radius     <= i_cfg_data[15:0];
                CFG_FALLOFF:  r_falloff    <= i_cfg_data[16:0];
                CFG_RATE:     r_rate       <= i_cfg_data[23:0];
                CFG_FLATTEN:  r_flatten    <= i_cfg_data[16:0];
                CFG_CHANNEL:  r_channel    <= i_cfg_data[1:0];
                default:      r_channel    <= r_channel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dflag     <= 1'b0;
            r_dlx       <= '0;
            r_dhx       <= '0;
            r_dlz       <= '0;
            r_dhz       <= '0;
            r_touched   <= 1'b0;
            r_pgo       <= 1'b0;
            r_pi        <= '0;
        end else begin
            if ((r_state == S_OUT) && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x       <= i_texel_x;
                        r_z       <= i_texel_z;
                        r_h       <= i_height;
                        r_newh    <= i_height;
                        r_sum5    <= 20'(i_height) + 20'(i_left_height) + 20'(i_right_height)
                                   + 20'(i_down_height) + 20'(i_up_height);
                        r_sp[0]   <= 26'(i_splat_in_0);
                        r_sp[1]   <= 26'(i_splat_in_1);
                        r_sp[2]   <= 26'(i_splat_in_2);
                        r_sp[3]   <= 26'(i_splat_in_3);
                        r_spo[0]  <= i_splat_in_0;
                        r_spo[1]  <= i_splat_in_1;
                        r_spo[2]  <= i_splat_in_2;
                        r_spo[3]  <= i_splat_in_3;
                        r_touched <= 1'b0;
                        r_pgo     <= 1'b0;
                        r_pi      <= '0;
                        if (i_stroke_start) begin
                            r_dflag <= 1'b0;
                            r_dlx   <= '0;
                            r_dhx   <= '0;
                            r_dlz   <= '0;
                            r_dhz   <= '0;
                        end
                        r_state   <= S_DX;
                    end
                end
                S_DX: begin
                    r_d2    <= mul_p[40:0];
                    r_state <= S_DZ;
                end
                S_DZ: begin
                    r_d2    <= r_d2 + mul_p[40:0];
                    r_state <= S_RR;
                end
                S_RR: begin
                    r_prod  <= mul_p;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!in_brush) begin
                        r_state <= S_OUT;
                    end else begin
                        r_touched <= 1'b1;
                        if (r_radius == 16'd0) begin
                            r_w     <= '0;
                            r_state <= S_AMT;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (du_done) r_state <= S_DIVT;
                end
                S_DIVT: begin
                    if (du_done) begin
                        if (t_v >= ONE_Q16) begin
                            r_w     <= '0;
                            r_state <= S_AMT;
                        end else if (t_v <= edge_v) begin
                            r_w     <= ONE_Q16;
                            r_state <= S_AMT;
                        end else begin
                            r_state <= S_DIVF;
                        end
                    end
                end
                S_DIVF: begin
                    if (du_done) begin
                        r_f     <= du_res[16:0];
                        r_state <= S_F2;
                    end
                end
                S_F2: begin
                    r_prod  <= mul_p;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_prod  <= mul_p;
                    r_state <= S_W;
                end
                S_W: begin
                    // smoothstep: 1 - f^2 (3 - 2f)
                    r_w     <= ONE_Q16 - r_prod[48:32];
                    r_state <= S_AMT;
                end
                S_AMT: begin
                    r_prod  <= mul_p;
                    r_state <= S_MODE;
                end
                S_MODE: begin
                    r_amt <= amt_v;
                    case (r_brush_mode)
                        MODE_RAISE: begin
                            r_newh  <= (rsum > 25'(ONE_Q16)) ? ONE_Q16 : rsum[16:0];
                            r_state <= S_OUT;
                        end
                        MODE_LOWER: begin
                            if (amt_v >= 24'(r_h)) r_newh <= '0;
                            else if ((24'(r_h) - amt_v) > 24'(ONE_Q16)) r_newh <= ONE_Q16;
                            else r_newh <= 17'(24'(r_h) - amt_v);
                            r_state <= S_OUT;
                        end
                        MODE_SMOOTH: begin
                            r_state <= S_AVG;
                        end
                        MODE_FLATTEN: begin
                            r_tgt   <= r_flatten;
                            r_state <= S_MV;
                        end
                        MODE_PAINT: begin
                            r_sp[r_channel] <= r_sp[r_channel] + {1'b0, amt_v, 1'b0};
                            r_state         <= S_PDIV;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_AVG: begin
                    // average of five heights by reciprocal multiply
                    r_tgt   <= mul_p[37:21];
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_prod  <= mul_p;
                    r_up    <= (r_tgt >= r_h);
                    r_state <= S_MV2;
                end
                S_MV2: begin
                    if (r_up) begin
                        r_newh <= (hsum > 28'(ONE_Q16)) ? ONE_Q16 : hsum[16:0];
                    end else if (mag >= 27'(r_h)) begin
                        r_newh <= '0;
                    end else if ((27'(r_h) - mag) > 27'(ONE_Q16)) begin
                        r_newh <= ONE_Q16;
                    end else begin
                        r_newh <= 17'(27'(r_h) - mag);
                    end
                    r_state <= S_OUT;
                end
                S_PDIV: begin
                    // each weight over the new total, one channel per divide
                    if (total == 26'd0) begin
                        r_state <= S_OUT;
                    end else if (!r_pgo) begin
                        r_pgo <= 1'b1;
                    end else if (du_done) begin
                        r_spo[r_pi] <= du_res[16:0];
                        r_pgo       <= 1'b0;
                        if (r_pi == 2'd3) r_state <= S_OUT;
                        else r_pi <= r_pi + 2'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_touched <= r_touched;
                        r_o_height  <= r_newh;
                        r_o_sp[0]   <= r_spo[0];
                        r_o_sp[1]   <= r_spo[1];
                        r_o_sp[2]   <= r_spo[2];
                        r_o_sp[3]   <= r_spo[3];
                        r_o_rvalid  <= n_dflag;
                        r_o_lx      <= n_dlx;
                        r_o_hx      <= n_dhx;
                        r_o_lz      <= n_dlz;
                        r_o_hz      <= n_dhz;
                        r_dflag     <= n_dflag;
                        r_dlx       <= n_dlx;
                        r_dhx       <= n_dhx;
                        r_dlz       <= n_dlz;
                        r_dhz       <= n_dhz;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_touched      = r_o_touched;
    assign o_new_height   = r_o_height;
    assign o_splat_out_0  = r_o_sp[0];
    assign o_splat_out_1  = r_o_sp[1];
    assign o_splat_out_2  = r_o_sp[2];
    assign o_splat_out_3  = r_o_sp[3];
    assign o_region_valid = r_o_rvalid;
    assign o_region_min_x = r_o_lx;
    assign o_region_max_x = r_o_hx;
    assign o_region_min_z = r_o_lz;
    assign o_region_max_z = r_o_hz;

    // a touched texel always leaves a valid dirty box
    a_touch_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_touched) |-> o_region_valid)
        else $error("touched word without valid region");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region_valid) |->
            (o_region_min_x <= o_region_max_x) && (o_region_min_z <= o_region_max_z))
        else $error("dirty box corners out of order");

    // the shared unit is never restarted while it is iterating
    a_du_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_ctl.start |-> !du_busy)
        else $error("divide/sqrt unit started while busy");

endmodule

>>> rtl/core/tbtu_divsqrt.sv
// shared iterative unit: 17-bit quotient restoring divide or 24-bit integer square root
module tbtu_divsqrt
    import tbtu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_du_ctl              i_ctl,
    input  logic [DU_OPND_W-1:0] i_opnd,
    input  logic [DU_DVSR_W-1:0] i_dvsr,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DU_RES_W-1:0]  o_result
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_sqrt;
    logic [4:0]           r_cnt;
    logic [DU_OPND_W-1:0] r_sh;
    logic [DU_REM_W-1:0]  r_rem;
    logic [DU_RES_W-1:0]  r_q;
    logic [DU_DVSR_W-1:0] r_dvsr;

    logic [DU_REM_W-1:0] cand;
    logic [DU_REM_W-1:0] opb;
    logic                ge;
    logic [DU_REM_W-1:0] diff;

    // one shared compare and subtract serves both operations
    always_comb begin
        if (r_sqrt) begin
            cand = {r_rem[DU_REM_W-3:0], r_sh[DU_OPND_W-1 -: 2]};
            opb  = {2'b00, r_q, 2'b01};
        end else begin
            cand = {r_rem[DU_REM_W-2:0], r_sh[DU_OPND_W-1]};
            opb  = {1'b0, r_dvsr};
        end
        ge   = (cand >= opb);
        diff = cand - opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.sqrt;
                r_dvsr <= i_dvsr;
                r_q    <= '0;
                if (i_ctl.sqrt) begin
                    r_rem <= '0;
                    r_sh  <= i_opnd;
                    r_cnt <= 5'd23;
                end else begin
                    // numerator is known to be below divisor * 2^17
                    r_rem <= i_opnd[DU_REM_W+16:17];
                    r_sh  <= {i_opnd[16:0], 31'd0};
                    r_cnt <= 5'd16;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff : cand;
                r_q   <= {r_q[DU_RES_W-2:0], ge};
                r_sh  <= r_sqrt ? {r_sh[DU_OPND_W-3:0], 2'b00} : {r_sh[DU_OPND_W-2:0], 1'b0};
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_q;

endmodule
